/* rtl/mp3fw_pkg.sv */
// ---------------------------------------------------------------------------
// mp3fw_pkg: shared types, constants and tables for the MP3 frame walker
// Record layout, status codes, queue sizing, frame length and rate tables.
// ---------------------------------------------------------------------------
package mp3fw_pkg;

  // Width of the running sample total (saturates at its all-ones value)
  localparam int unsigned SAMPLE_COUNT_BITS = 32;

  // Result queue sizing
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Tag and header markers
  localparam logic [23:0] Id3Mark = 24'h494433;
  localparam logic [23:0] Ea3Mark = 24'h656133;
  localparam logic [23:0] TagMark = 24'h544147;
  localparam logic [31:0] SyncMask = 32'hFFE0_0000;

  // Samples per frame
  localparam logic [10:0] SamplesV1 = 11'd1152;
  localparam logic [10:0] SamplesV2 = 11'd576;

  // Record kinds
  typedef enum logic [1:0] {
    ST_FRAME    = 2'd0,
    ST_TAG_END  = 2'd1,
    ST_BAD_END  = 2'd2,
    ST_DATA_END = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [10:0] frame_bytes;
    logic [15:0] sample_rate_hz;
    logic        mpeg_version;
    logic [31:0] total_samples;
  } rec_t;

  // Up to two records leave the parser per byte, in order
  typedef struct packed {
    logic push0;
    logic push1;
    rec_t rec0;
    rec_t rec1;
  } push_t;

  // Frame lengths without padding, per version and rate index, by bitrate index
  localparam logic [10:0] LenV1R0 [0:15] = '{
    11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
    11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0};
  localparam logic [10:0] LenV1R1 [0:15] = '{
    11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
    11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0};
  localparam logic [10:0] LenV1R2 [0:15] = '{
    11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
    11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0};
  localparam logic [10:0] LenV2R0 [0:15] = '{
    11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
    11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0};
  localparam logic [10:0] LenV2R1 [0:15] = '{
    11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
    11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0};
  localparam logic [10:0] LenV2R2 [0:15] = '{
    11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
    11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0};

  // Frame length ROM lookup (padding not included)
  function automatic logic [10:0] frame_len(logic ver, logic [3:0] br, logic [1:0] sri);
    logic [10:0] len;
    len = 11'd0;
    unique case ({ver, sri})
      3'b000:  len = LenV1R0[br];
      3'b001:  len = LenV1R1[br];
      3'b010:  len = LenV1R2[br];
      3'b100:  len = LenV2R0[br];
      3'b101:  len = LenV2R1[br];
      3'b110:  len = LenV2R2[br];
      default: len = 11'd0;
    endcase
    return len;
  endfunction

  // Sample rate, halved for MPEG2
  function automatic logic [15:0] rate_hz(logic ver, logic [1:0] sri);
    logic [15:0] hz;
    hz = 16'd0;
    unique case ({ver, sri})
      3'b000:  hz = 16'd44100;
      3'b001:  hz = 16'd48000;
      3'b010:  hz = 16'd32000;
      3'b100:  hz = 16'd22050;
      3'b101:  hz = 16'd24000;
      3'b110:  hz = 16'd16000;
      default: hz = 16'd0;
    endcase
    return hz;
  endfunction

endpackage

/* rtl/mp3fw_parse.sv */
// ---------------------------------------------------------------------------
// mp3fw_parse: byte-level frame walker
// Holds the walk state, decodes tag and frame headers and builds records.
// ---------------------------------------------------------------------------
module mp3fw_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output mp3fw_pkg::push_t  push_o
);

  localparam logic [2:0] PH_TAGHDR = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;

  localparam int unsigned SW = mp3fw_pkg::SAMPLE_COUNT_BITS;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [23:0] shift_q, shift_d;
  logic [28:0] skip_q, skip_d;
  logic [7:0]  flags_q, flags_d;
  logic [SW-1:0] total_q, total_d;

  // Header decode
  logic [31:0]   hdr;
  logic          hdr_tag, hdr_bad, hdr_ver;
  logic [1:0]    ver_bits, sri;
  logic [3:0]    br;
  logic [10:0]   hdr_len;
  logic [15:0]   hdr_hz;
  logic [SW:0]   total_sum;
  logic [SW-1:0] total_sat;
  logic          take;

  assign hdr      = {shift_q, byte_i};
  assign ver_bits = hdr[20:19];
  assign br       = hdr[15:12];
  assign sri      = hdr[11:10];
  assign hdr_tag  = (shift_q == mp3fw_pkg::TagMark);
  assign hdr_bad  = ((hdr & mp3fw_pkg::SyncMask) != mp3fw_pkg::SyncMask) ||
                    (ver_bits[1] == 1'b0) || (br == 4'd0) || (br == 4'd15) ||
                    (sri == 2'd3);
  assign hdr_ver  = ~ver_bits[0];
  assign hdr_len  = mp3fw_pkg::frame_len(hdr_ver, br, sri) + {10'd0, hdr[9]};
  assign hdr_hz   = mp3fw_pkg::rate_hz(hdr_ver, sri);

  // Saturating sample total
  assign total_sum = {1'b0, total_q} +
                     (SW+1)'(hdr_ver ? mp3fw_pkg::SamplesV2 : mp3fw_pkg::SamplesV1);
  assign total_sat = total_sum[SW] ? {SW{1'b1}} : total_sum[SW-1:0];

  // Next state and records for one byte
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    shift_d = shift_q;
    skip_d  = skip_q;
    flags_d = flags_q;
    total_d = total_q;
    take    = 1'b0;
    push_o  = '0;

    unique case (phase_q)
      PH_TAGHDR: begin
        if (pos_q < 4'd3) begin
          shift_d = {shift_q[15:0], byte_i};
          pos_d   = pos_q + 4'd1;
        end else if (pos_q == 4'd3 && shift_q != mp3fw_pkg::Id3Mark &&
                     shift_q != mp3fw_pkg::Ea3Mark) begin
          take = 1'b1;
        end else begin
          if (pos_q == 4'd5) flags_d = byte_i;
          if (pos_q == 4'd6) skip_d = {22'd0, byte_i[6:0]};
          if (pos_q > 4'd6)  skip_d = {skip_q[21:0], byte_i[6:0]};
          if (pos_q >= 4'd9) begin
            if (flags_q[4]) skip_d = skip_d + 29'd10;
            pos_d   = 4'd0;
            phase_d = (skip_d == 29'd0) ? PH_HEADER : PH_SKIP;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      PH_SKIP: begin
        if (skip_q != 29'd0) skip_d = skip_q - 29'd1;
        if (skip_d == 29'd0) begin
          phase_d = PH_HEADER;
          pos_d   = 4'd0;
        end
      end
      PH_HEADER: begin
        if (pos_q < 4'd3) begin
          shift_d = {shift_q[15:0], byte_i};
          pos_d   = pos_q + 4'd1;
        end else begin
          take = 1'b1;
        end
      end
      default: ;
    endcase

    // Complete header: frame, TAG end or bad-header end
    if (take) begin
      push_o.push0 = 1'b1;
      if (hdr_tag) begin
        phase_d = PH_DONE;
        push_o.rec0.status = mp3fw_pkg::ST_TAG_END;
      end else if (hdr_bad) begin
        phase_d = PH_DONE;
        push_o.rec0.status = mp3fw_pkg::ST_BAD_END;
      end else begin
        total_d = total_sat;
        skip_d  = {18'd0, hdr_len - 11'd4};
        pos_d   = 4'd0;
        phase_d = (skip_d == 29'd0) ? PH_HEADER : PH_SKIP;
        push_o.rec0.status         = mp3fw_pkg::ST_FRAME;
        push_o.rec0.frame_bytes    = hdr_len;
        push_o.rec0.sample_rate_hz = hdr_hz;
        push_o.rec0.mpeg_version   = hdr_ver;
      end
      push_o.rec0.total_samples = 32'(total_d);
    end

    // Final byte: end-of-data record unless already ended, then restart
    if (last_i) begin
      if (phase_d != PH_DONE) begin
        if (take) begin
          push_o.push1 = 1'b1;
          push_o.rec1.status        = mp3fw_pkg::ST_DATA_END;
          push_o.rec1.total_samples = 32'(total_d);
        end else begin
          push_o.push0 = 1'b1;
          push_o.rec0.status        = mp3fw_pkg::ST_DATA_END;
          push_o.rec0.total_samples = 32'(total_d);
        end
      end
      phase_d = PH_TAGHDR;
      pos_d   = 4'd0;
      shift_d = 24'd0;
      skip_d  = 29'd0;
      flags_d = 8'd0;
      total_d = '0;
    end

    if (!step_i) push_o = '0;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAGHDR;
      pos_q   <= 4'd0;
      shift_q <= 24'd0;
      skip_q  <= 29'd0;
      flags_q <= 8'd0;
      total_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      skip_q  <= skip_d;
      flags_q <= flags_d;
      total_q <= total_d;
    end
  end

endmodule

/* rtl/mp3fw_outq.sv */
// ---------------------------------------------------------------------------
// mp3fw_outq: result record queue
// Four-entry queue taking up to two records a cycle and giving one when ready.
// ---------------------------------------------------------------------------
module mp3fw_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mp3fw_pkg::push_t  push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mp3fw_pkg::rec_t   rec_o,
  output logic [mp3fw_pkg::QCntW-1:0] count_o
);

  mp3fw_pkg::rec_t mem_q [mp3fw_pkg::QDepth];

  logic [mp3fw_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [mp3fw_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                        pop;
  logic [mp3fw_pkg::QPtrW-1:0] wr_nxt;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign rec_o   = mem_q[rd_q];
  assign count_o = cnt_q;
  // two free entries so that any byte can be taken
  assign room_o  = (cnt_q <= mp3fw_pkg::QCntW'(mp3fw_pkg::QDepth - 2));
  assign wr_nxt  = wr_q + mp3fw_pkg::QPtrW'(1);

  // Pointer and fill arithmetic
  always_comb begin
    wr_d  = wr_q + mp3fw_pkg::QPtrW'(push_i.push0) + mp3fw_pkg::QPtrW'(push_i.push1);
    rd_d  = rd_q + mp3fw_pkg::QPtrW'(pop);
    cnt_d = cnt_q + mp3fw_pkg::QCntW'(push_i.push0) + mp3fw_pkg::QCntW'(push_i.push1)
            - mp3fw_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Record storage
  always_ff @(posedge clk_i) begin
    if (push_i.push0) mem_q[wr_q] <= push_i.rec0;
    if (push_i.push1) mem_q[wr_nxt] <= push_i.rec1;
  end

endmodule

/* rtl/mp3fw_parse_top_note.sv */
// ---------------------------------------------------------------------------
// mp3fw_inreg: input word register
// Holds one accepted byte until the walker can take it.
// ---------------------------------------------------------------------------
module mp3fw_inreg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       room_i,
  output logic       step_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign step_o  = vld_q && room_i;
  assign ready_o = !vld_q || step_o;
  assign load    = valid_i && ready_o;
  assign vld_d   = load || (vld_q && !step_o);
  assign byte_o  = byte_q;
  assign last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

endmodule

/* rtl/mp3_frame_walker_unit.sv */
// ---------------------------------------------------------------------------
// mp3_frame_walker_unit: MPEG audio layer 3 frame walker
// Skips a leading tag, walks frame headers and reports each frame.
// ---------------------------------------------------------------------------
// Channel   Dir  Word
// s_axis    in   tdata[7:0] file byte, tlast final byte of the file
// m_axis    out  tuser[1:0] status, tdata frame/rate/version/sample total
//
// One byte is taken every cycle while the queue has room; a byte passes the
// input register, the walker state update and the four-entry result queue,
// which offers the byte's record once written. The walker takes a byte only
// while the queue has two free entries (a final byte may close a frame and
// the file at once).
// Reset clears the walker to the tag header phase and empties the queue.
// ---------------------------------------------------------------------------
module mp3_frame_walker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [10:0] frame_bytes, [26:11] sample_rate_hz,
                                      // [27] mpeg_version, [59:28] total_samples
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic                          room_w, step_w, last_w;
  logic [7:0]                    byte_w;
  mp3fw_pkg::push_t              push_w;
  mp3fw_pkg::rec_t               rec_w;
  logic [mp3fw_pkg::QCntW-1:0]   count_w;

  // Input register
  mp3fw_inreg u_inreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .room_i  (room_w),
    .step_o  (step_w),
    .byte_o  (byte_w),
    .last_o  (last_w)
  );

  // Walker
  mp3fw_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_w),
    .byte_i (byte_w),
    .last_i (last_w),
    .push_o (push_w)
  );

  // Result queue
  mp3fw_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .room_o  (room_w),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rec_o   (rec_w),
    .count_o (count_w)
  );

  // Output word packing
  assign m_axis_tuser = rec_w.status;
  assign m_axis_tdata = {4'd0, rec_w.total_samples, rec_w.mpeg_version,
                         rec_w.sample_rate_hz, rec_w.frame_bytes};

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_w <= mp3fw_pkg::QCntW'(mp3fw_pkg::QDepth))
    else $error("result queue overfilled");

  // a second record only follows a first, and only as end of data on a final byte
  a_second_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_w.push1 |-> (push_w.push0 && last_w &&
                      push_w.rec1.status == mp3fw_pkg::ST_DATA_END))
    else $error("unexpected second record");

  // records only appear for a byte the walker actually took
  a_push_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_w.push0 |-> step_w)
    else $error("record without a byte");
`endif

endmodule
